// File: design/mcr_pkg.sv
package mcr_pkg;

	localparam int IN_COORD_W = 10;
	localparam int PIX_W      = 12;
	localparam int COLOUR_W   = 8;
	localparam int NUM_OCT    = 8;
	localparam int OCT_IDX_W  = 3;

	localparam logic KIND_START = 1'b0;
	localparam logic KIND_STEP  = 1'b1;

	// Index of the last octant emitted in full and in half-circle mode.
	localparam logic [OCT_IDX_W-1:0] LAST_OCT_FULL = 3'd7;
	localparam logic [OCT_IDX_W-1:0] LAST_OCT_HALF = 3'd3;

	typedef struct packed {
		logic                  kind;
		logic [IN_COORD_W-1:0] center_x;
		logic [IN_COORD_W-1:0] center_y;
		logic [IN_COORD_W-1:0] radius;
		logic [COLOUR_W-1:0]   colour;
		logic                  arc_mode;
	} cmd_t;

	typedef struct packed {
		logic signed [PIX_W-1:0] pixel_x;
		logic signed [PIX_W-1:0] pixel_y;
		logic [COLOUR_W-1:0]     pixel_colour;
		logic                    last;
	} pix_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic                 load;
		logic                 step_y;
		logic                 step_x;
		logic                 commit;
		logic                 emit;
		logic                 final_pix;
		logic [OCT_IDX_W-1:0] oct;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic half_only;
		logic done;
	} dp_stat_t;

	// Operand choice for one octant pixel. The row uses x when the column uses y.
	typedef struct packed {
		logic col_use_y;
		logic col_neg;
		logic row_neg;
	} oct_sel_t;

	function automatic oct_sel_t oct_sel(input logic [OCT_IDX_W-1:0] k);
		oct_sel_t s;
		s.col_use_y = (k == 3'd1) || (k == 3'd2) || (k == 3'd5) || (k == 3'd6);
		s.col_neg   = (k == 3'd2) || (k == 3'd3) || (k == 3'd4) || (k == 3'd5);
		s.row_neg   = k[2];
		return s;
	endfunction

endpackage

// File: design/mcr_ctrl.sv
module mcr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              kind,
	input  mcr_pkg::dp_stat_t stat,
	output mcr_pkg::dp_cmd_t  cmd,
	output logic              busy
);
	import mcr_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EMIT = 1'b1;

	logic                 state_q;
	logic [OCT_IDX_W-1:0] k_q;
	logic                 active_q;
	logic [OCT_IDX_W-1:0] last_k;
	logic                 accept;

	assign busy   = (state_q == ST_EMIT);
	assign accept = start && !busy;
	assign last_k = stat.half_only ? LAST_OCT_HALF : LAST_OCT_FULL;

	always_comb begin
		cmd           = '0;
		cmd.load      = accept && (kind == KIND_START);
		cmd.emit      = busy;
		cmd.oct       = k_q;
		cmd.step_y    = busy && (k_q == '0);
		cmd.step_x    = busy && (k_q == OCT_IDX_W'(1));
		cmd.final_pix = busy && (k_q == last_k);
		cmd.commit    = cmd.final_pix;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			k_q      <= '0;
			active_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					// drop a step beat while no circle is running
					if (accept && (kind == KIND_START || active_q)) begin
						state_q  <= ST_EMIT;
						active_q <= 1'b1;
					end
				end
				ST_EMIT: begin
					if (cmd.final_pix) begin
						state_q  <= ST_IDLE;
						active_q <= !stat.done;
						k_q      <= '0;
					end else begin
						k_q <= k_q + OCT_IDX_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: design/mcr_datapath.sv
module mcr_datapath #(
	parameter int COORD_BITS = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  mcr_pkg::cmd_t     in_cmd,
	input  mcr_pkg::dp_cmd_t  ctl,
	output mcr_pkg::dp_stat_t stat,
	output mcr_pkg::pix_t     pix,
	output logic              strobe
);
	import mcr_pkg::*;

	localparam int X_W   = COORD_BITS + 1;
	localparam int E_W   = COORD_BITS + 3;
	localparam int SUM_W = COORD_BITS + 3;

	logic [COORD_BITS-1:0] cx_q, cy_q;
	logic [COLOUR_W-1:0]   colour_q;
	logic                  half_q;
	logic signed [X_W-1:0] x_q, y_q, x1_q, y1_q;
	logic signed [E_W-1:0] e_q, e1_q, e2_q;
	logic                  done_q;

	logic signed [E_W-1:0]   y_ext, x_ext;
	logic signed [X_W-1:0]   y_inc, x_dec;
	oct_sel_t                sel;
	logic signed [X_W-1:0]   col_op, row_op;
	logic signed [SUM_W-1:0] cx_ext, cy_ext, col_ext, row_ext, col_sum, row_sum;

	assign stat.half_only = half_q;
	assign stat.done      = done_q;

	assign y_ext = E_W'(y_q);
	assign x_ext = E_W'(x_q);
	assign y_inc = y_q + X_W'(1);
	assign x_dec = x_q - X_W'(1);

	// octant pixel: column and row each add or subtract one offset
	assign sel     = oct_sel(ctl.oct);
	assign col_op  = sel.col_use_y ? y_q : x_q;
	assign row_op  = sel.col_use_y ? x_q : y_q;
	assign cx_ext  = SUM_W'(signed'({1'b0, cx_q}));
	assign cy_ext  = SUM_W'(signed'({1'b0, cy_q}));
	assign col_ext = SUM_W'(col_op);
	assign row_ext = SUM_W'(row_op);
	assign col_sum = sel.col_neg ? (cx_ext - col_ext) : (cx_ext + col_ext);
	assign row_sum = sel.row_neg ? (cy_ext - row_ext) : (cy_ext + row_ext);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cx_q     <= COORD_BITS'(in_cmd.center_x);
			cy_q     <= COORD_BITS'(in_cmd.center_y);
			colour_q <= in_cmd.colour;
			half_q   <= in_cmd.arc_mode;
			x_q      <= signed'({1'b0, COORD_BITS'(in_cmd.radius)});
			y_q      <= '0;
			e_q      <= '0;
		end else if (ctl.commit) begin
			x_q <= x1_q;
			y_q <= y1_q;
			e_q <= e2_q;
		end

		// advance the minor offset first
		if (ctl.step_y) begin
			if (e_q <= 0) begin
				y1_q <= y_inc;
				e1_q <= e_q + (y_ext <<< 1) + E_W'(3);
			end else begin
				y1_q <= y_q;
				e1_q <= e_q;
			end
		end

		// then the major offset, on the error left by the minor step
		if (ctl.step_x) begin
			if (e1_q > 0) begin
				x1_q   <= x_dec;
				e2_q   <= e1_q - (x_ext <<< 1) + E_W'(1);
				done_q <= (x_dec < y1_q);
			end else begin
				x1_q   <= x_q;
				e2_q   <= e1_q;
				done_q <= (x_q < y1_q);
			end
		end

		if (ctl.emit) begin
			pix.pixel_x      <= PIX_W'(col_sum);
			pix.pixel_y      <= PIX_W'(row_sum);
			pix.pixel_colour <= colour_q;
			pix.last         <= ctl.final_pix && done_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe <= 1'b0;
		end else begin
			strobe <= ctl.emit;
		end
	end

endmodule

// File: design/midpoint_circle_rasterizer.sv
// Midpoint circle rasterizer: one iteration per command beat, one pixel beat per cycle within a burst.
// Each pixel is registered onto pix and strobe after the controller has entered its emit state.
// A new command beat is taken only after a burst of 8 pixels (4 in half-circle mode) and a return to idle.
// A step beat while no circle is running is taken and yields nothing.
// Reset (arst_n low, asynchronous) returns to idle with no circle running.
// Pixel beats cannot be stalled: each one shows for exactly one cycle on strobe.
module midpoint_circle_rasterizer #(
	parameter int COORD_BITS = 10
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  mcr_pkg::cmd_t cmd,
	output logic          strobe,
	output mcr_pkg::pix_t pix
);
	import mcr_pkg::*;

	// Controller: holds the octant counter and the running flag, sequences
	// the minor step, the major step and the commit around the pixel beats.
	dp_cmd_t  ctl;
	dp_stat_t stat;

	mcr_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.kind   (cmd.kind),
		.stat   (stat),
		.cmd    (ctl),
		.busy   (busy)
	);

	// Datapath: centre, offsets and error term, one shared adder pair for
	// the pixel coordinates, and the registered pixel output.
	mcr_datapath #(
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.in_cmd (cmd),
		.ctl    (ctl),
		.stat   (stat),
		.pix    (pix),
		.strobe (strobe)
	);

endmodule

// File: design/mcr_checker.sv
module mcr_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input mcr_pkg::cmd_t cmd,
	input logic          strobe,
	input mcr_pkg::pix_t pix
);
	import mcr_pkg::*;

	// a start beat always runs an iteration
	a_start_runs: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && cmd.kind == KIND_START |=> busy)
		else $error("start beat did not begin an iteration");

	// pixel beats come only out of a busy cycle
	a_strobe_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy))
		else $error("pixel beat without a running iteration");

	// the final pixel closes the burst
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && pix.last |=> !strobe)
		else $error("pixel beat after the final pixel");

	// one burst keeps one colour
	a_colour_hold: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && $past(strobe) |-> $stable(pix.pixel_colour))
		else $error("colour changed within a burst");

endmodule

bind midpoint_circle_rasterizer mcr_checker u_mcr_checker (.*);
